// File: rtl/twg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the sine table builder for the tone generator
package twg_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_BSTART,
        S_BWAIT,
        S_WAVE,
        S_SWAIT,
        S_SROM,
        S_SMUL,
        S_TSTART,
        S_TWAIT,
        S_SCALE,
        S_CWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // configuration register indexes
    localparam logic [2:0] CFG_WAVEFORM  = 3'd0;
    localparam logic [2:0] CFG_FREQUENCY = 3'd1;
    localparam logic [2:0] CFG_AMPLITUDE = 3'd2;
    localparam logic [2:0] CFG_FRAMES    = 3'd3;
    localparam logic [2:0] CFG_STEREO    = 3'd4;
    localparam logic [2:0] CFG_WIDTH     = 3'd5;

    // waveform codes
    localparam logic [1:0] WAVE_SILENCE  = 2'd0;
    localparam logic [1:0] WAVE_SINE     = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    localparam logic [17:0] PHASE_MOD   = 18'd244800;
    localparam logic [16:0] HALF_NUM    = 17'd122400;
    localparam logic [3:0]  HALF_DEN    = 4'd11;
    localparam logic [12:0] FREQ_MAX    = 13'd5000;
    localparam logic [6:0]  PCT_DIV     = 7'd100;
    localparam logic [16:0] PEAK_WIDE   = 17'd32767;
    localparam logic [16:0] PEAK_NARROW = 17'd127;
    localparam logic [16:0] FULL_WIDE   = 17'd65535;
    localparam logic [16:0] FULL_NARROW = 17'd256;
    localparam logic [16:0] NEG_LIMIT   = 17'd32768;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // quarter sine entry in q1.30, taylor series to 15th order, evaluated at elaboration
    function automatic logic [30:0] sine_entry(input int unsigned idx, input int unsigned tb);
        logic [63:0]    a;
        logic [63:0]    a2;
        logic [63:0]    term;
        longint         sum;
        int unsigned    k;
        a    = (HALF_PI_Q30 * 64'(idx)) >> tb;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (k = 1; k <= 7; k++) begin
            term = (term * a2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (k[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
        if (idx == 0) sum = 0;
        if (idx == (32'd1 << tb)) sum = longint'(Q30_ONE);
        return 31'(sum);
    endfunction

endpackage

// File: rtl/twg_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module twg_div #(
    parameter int NW = 57,
    parameter int DW = 41,
    parameter int CW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CW-1:0]    i_len,
    input  logic [NW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    output twg_pkg::t_div_sts o_sts,
    output logic [NW-1:0]    o_quot
);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;

endmodule

// File: rtl/tone_waveform_generator_unit.sv
`timescale 1ns / 1ps
// tone generator: at most one frame per input beat, silence, sine, square or triangle, mono or stereo
// each frame runs serial divisions on the shared divider: one at a half-period boundary,
//   then one for the sine table index (sine) or the triangle ramp (triangle), then one for
//   the amplitude scale
// one frame is worked on at a time; the next beat is taken after the last output beat
// reset (synchronous, active low) loads register defaults and leaves the tone finished
module tone_waveform_generator_unit #(
    parameter int FRAME_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic [0:0]  m_axis_tuser,   // [0] channel
    output logic        m_axis_tlast
);

    localparam int FB = FRAME_BITS;
    localparam int TB = SINE_TABLE_BITS;
    localparam int QW = FB + 17;
    localparam int NW = QW + 16;
    localparam int CW = $clog2(NW + 1);
    localparam int SL = TB + 20;
    localparam int AL = 25;
    localparam int SN = 1 << TB;
    localparam logic [CW-1:0] LEN_BND   = CW'(QW);
    localparam logic [CW-1:0] LEN_SINE  = CW'(SL);
    localparam logic [CW-1:0] LEN_TRI   = CW'(NW);
    localparam logic [CW-1:0] LEN_SCALE = CW'(AL);

    twg_pkg::t_state   r_state, n_state;

    logic [1:0]        r_waveform;
    logic [12:0]       r_tone_frequency;
    logic [7:0]        r_amplitude_percent;
    logic [23:0]       r_frame_count;
    logic              r_stereo;
    logic              r_sample_width;

    logic [FB-1:0]     r_frame_index;
    logic [FB-1:0]     r_bcount;
    logic [QW-1:0]     r_bframe;
    logic              r_bneg;
    logic [QW-1:0]     r_hlen;
    logic              r_square_high;
    logic              r_ramp_down;
    logic [17:0]       r_sine_phase;
    logic              r_finished;
    logic              r_chan;
    logic              r_last;

    logic [QW-1:0]     r_tnum;
    logic [TB:0]       r_uidx;
    logic [30:0]       r_mag;
    logic [16:0]       r_rmag;
    logic              r_rneg;
    logic [15:0]       r_sample;

    logic              w_start;
    logic [CW-1:0]     w_len;
    logic [NW-1:0]     w_num;
    logic [QW-1:0]     w_den;
    twg_pkg::t_div_sts w_sts;
    logic [NW-1:0]     w_quot;

    logic [12:0]       w_freq;
    logic [FB-1:0]     w_fc;
    logic              w_new_bnd;
    logic [16:0]       w_peak;
    logic [QW-1:0]     w_hl1;
    logic [QW-1:0]     w_d;
    logic [QW-1:0]     w_dc;
    logic [QW-1:0]     w_n1;
    logic [QW-1:0]     w_nb;
    logic [NW-1:0]     w_tprod;
    logic [AL-1:0]     w_sprod;
    logic [46:0]       w_sprod_sine;
    logic [TB+1:0]     w_u;
    logic [16:0]       w_q17;
    logic [16:0]       w_lim;
    logic [16:0]       w_mc;
    logic [18:0]       w_ph;
    logic [30:0]       w_rom [0:SN];

    // quarter-wave rom, constant entries
    for (genvar gi = 0; gi <= SN; gi++) begin : g_rom
        localparam logic [30:0] ENTRY = twg_pkg::sine_entry(gi, TB);
        assign w_rom[gi] = ENTRY;
    end

    assign w_freq = (r_tone_frequency == 13'd0) ? 13'd1 :
                    (r_tone_frequency > twg_pkg::FREQ_MAX) ? twg_pkg::FREQ_MAX :
                    r_tone_frequency;
    assign w_fc      = FB'(r_frame_count);
    assign w_new_bnd = r_bneg || (QW'(r_frame_index) > r_bframe);
    assign w_peak    = r_sample_width ? twg_pkg::PEAK_WIDE : twg_pkg::PEAK_NARROW;

    // triangle position within the half period
    assign w_hl1 = (r_hlen == '0) ? QW'(1) : r_hlen;
    assign w_d   = r_bframe - QW'(r_frame_index);
    assign w_dc  = (w_d > w_hl1) ? w_hl1 : w_d;

    // next boundary, kept ahead of the current frame
    assign w_n1 = QW'(r_frame_index) + QW'(1);
    assign w_nb = (w_quot[QW-1:0] < w_n1) ? w_n1 : w_quot[QW-1:0];

    // full scale is 2^16-1 or 2^8, so the product is a shift, with a subtract for the wide case
    assign w_tprod      = r_sample_width ? ((NW'(r_tnum) << 16) - NW'(r_tnum)) :
                                           (NW'(r_tnum) << 8);
    assign w_sprod      = AL'(r_rmag) * AL'(r_amplitude_percent);
    assign w_sprod_sine = 47'(w_peak) * 47'(r_mag);
    assign w_u          = w_quot[TB+1:0];
    assign w_q17        = w_quot[16:0];

    // clip limits: negative wide side reaches one further
    assign w_lim = !r_sample_width ? twg_pkg::PEAK_NARROW :
                   r_rneg ? twg_pkg::NEG_LIMIT : twg_pkg::PEAK_WIDE;
    assign w_mc  = (w_q17 >= w_lim) ? w_lim : w_q17;
    assign w_ph  = 19'(r_sine_phase) + 19'(17'(w_freq) * 17'(twg_pkg::HALF_DEN));

    twg_div #(
        .NW (NW),
        .DW (QW),
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_len   (w_len),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_sts   (w_sts),
        .o_quot  (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            twg_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = twg_pkg::S_CHECK;
            end
            twg_pkg::S_CHECK: begin
                if (r_finished || (r_frame_index >= w_fc)) n_state = twg_pkg::S_IDLE;
                else if (w_new_bnd)                        n_state = twg_pkg::S_BSTART;
                else                                       n_state = twg_pkg::S_WAVE;
            end
            twg_pkg::S_BSTART: n_state = twg_pkg::S_BWAIT;
            twg_pkg::S_BWAIT: begin
                if (w_sts.done) n_state = twg_pkg::S_WAVE;
            end
            twg_pkg::S_WAVE: begin
                unique case (r_waveform)
                    twg_pkg::WAVE_SINE:     n_state = twg_pkg::S_SWAIT;
                    twg_pkg::WAVE_TRIANGLE: n_state = twg_pkg::S_TSTART;
                    default:                n_state = twg_pkg::S_SCALE;
                endcase
            end
            twg_pkg::S_SWAIT: begin
                if (w_sts.done) n_state = twg_pkg::S_SROM;
            end
            twg_pkg::S_SROM:   n_state = twg_pkg::S_SMUL;
            twg_pkg::S_SMUL:   n_state = twg_pkg::S_SCALE;
            twg_pkg::S_TSTART: n_state = twg_pkg::S_TWAIT;
            twg_pkg::S_TWAIT: begin
                if (w_sts.done) n_state = twg_pkg::S_SCALE;
            end
            twg_pkg::S_SCALE:  n_state = twg_pkg::S_CWAIT;
            twg_pkg::S_CWAIT: begin
                if (w_sts.done) n_state = twg_pkg::S_OUT;
            end
            twg_pkg::S_OUT: begin
                if (m_axis_tready && !(r_stereo && !r_chan)) n_state = twg_pkg::S_IDLE;
            end
            default: n_state = twg_pkg::S_IDLE;
        endcase
    end

    // handshake and divider launch
    always_comb begin
        s_axis_tready = (r_state == twg_pkg::S_IDLE);
        m_axis_tvalid = (r_state == twg_pkg::S_OUT);
        w_start       = 1'b0;
        w_len         = LEN_BND;
        w_num         = '0;
        w_den         = QW'(1);
        unique case (r_state)
            twg_pkg::S_BSTART: begin
                w_start = 1'b1;
                w_len   = LEN_BND;
                w_num   = NW'(QW'(r_bcount) * QW'(twg_pkg::HALF_NUM)) << (NW - QW);
                w_den   = QW'(17'(w_freq) * 17'(twg_pkg::HALF_DEN));
            end
            twg_pkg::S_WAVE: begin
                w_start = (r_waveform == twg_pkg::WAVE_SINE);
                w_len   = LEN_SINE;
                w_num   = NW'({r_sine_phase, {(TB + 2){1'b0}}}) << (NW - SL);
                w_den   = QW'(twg_pkg::PHASE_MOD);
            end
            twg_pkg::S_TSTART: begin
                w_start = 1'b1;
                w_len   = LEN_TRI;
                w_num   = w_tprod;
                w_den   = w_hl1;
            end
            twg_pkg::S_SCALE: begin
                w_start = 1'b1;
                w_len   = LEN_SCALE;
                w_num   = NW'(w_sprod) << (NW - AL);
                w_den   = QW'(twg_pkg::PCT_DIV);
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    // control, configuration and tone position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= twg_pkg::S_IDLE;
            r_waveform          <= twg_pkg::WAVE_SILENCE;
            r_tone_frequency    <= 13'd440;
            r_amplitude_percent <= 8'd100;
            r_frame_count       <= 24'd1;
            r_stereo            <= 1'b0;
            r_sample_width      <= 1'b1;
            r_frame_index       <= '0;
            r_bcount            <= '0;
            r_bframe            <= '0;
            r_bneg              <= 1'b1;
            r_hlen              <= '0;
            r_square_high       <= 1'b1;
            r_ramp_down         <= 1'b1;
            r_sine_phase        <= '0;
            r_finished          <= 1'b1;
            r_chan              <= 1'b0;
            r_last              <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    twg_pkg::CFG_WAVEFORM:  r_waveform          <= i_cfg_data[1:0];
                    twg_pkg::CFG_FREQUENCY: r_tone_frequency    <= i_cfg_data[12:0];
                    twg_pkg::CFG_AMPLITUDE: r_amplitude_percent <= i_cfg_data[7:0];
                    twg_pkg::CFG_FRAMES:    r_frame_count       <= i_cfg_data;
                    twg_pkg::CFG_STEREO:    r_stereo            <= i_cfg_data[0];
                    twg_pkg::CFG_WIDTH:     r_sample_width      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                twg_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tdata[0]) begin
                        r_frame_index <= '0;
                        r_bcount      <= '0;
                        r_bframe      <= '0;
                        r_bneg        <= 1'b1;
                        r_hlen        <= '0;
                        r_square_high <= 1'b1;
                        r_ramp_down   <= 1'b1;
                        r_sine_phase  <= '0;
                        r_finished    <= 1'b0;
                    end
                end
                twg_pkg::S_CHECK: begin
                    if (!r_finished && (r_frame_index >= w_fc)) r_finished <= 1'b1;
                    else if (w_new_bnd)                         r_bcount <= r_bcount + FB'(1);
                end
                twg_pkg::S_BWAIT: begin
                    if (w_sts.done) begin
                        r_bframe      <= w_nb;
                        r_bneg        <= 1'b0;
                        r_hlen        <= w_nb - QW'(r_frame_index);
                        r_square_high <= !r_square_high;
                        r_ramp_down   <= !r_ramp_down;
                    end
                end
                twg_pkg::S_CWAIT: begin
                    if (w_sts.done) begin
                        r_sine_phase  <= (w_ph >= 19'(twg_pkg::PHASE_MOD)) ?
                                         18'(w_ph - 19'(twg_pkg::PHASE_MOD)) : w_ph[17:0];
                        r_frame_index <= r_frame_index + FB'(1);
                        r_last        <= ((FB + 1)'(r_frame_index) + (FB + 1)'(1))
                                         >= (FB + 1)'(w_fc);
                        if (((FB + 1)'(r_frame_index) + (FB + 1)'(1)) >= (FB + 1)'(w_fc))
                            r_finished <= 1'b1;
                        r_chan        <= 1'b0;
                    end
                end
                twg_pkg::S_OUT: begin
                    if (m_axis_tready) r_chan <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sample datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            twg_pkg::S_WAVE: begin
                r_tnum <= r_ramp_down ? w_dc : (w_hl1 - w_dc);
                if (r_waveform == twg_pkg::WAVE_SQUARE) begin
                    r_rmag <= w_peak;
                    r_rneg <= !r_square_high;
                end else begin
                    r_rmag <= '0;
                    r_rneg <= 1'b0;
                end
            end
            twg_pkg::S_SWAIT: begin
                // odd quadrants read the table mirrored, upper half is negative
                r_uidx <= w_u[TB] ? ((TB + 1)'(SN) - {1'b0, w_u[TB-1:0]}) : {1'b0, w_u[TB-1:0]};
                r_rneg <= w_u[TB+1];
            end
            twg_pkg::S_SROM: r_mag  <= w_rom[r_uidx];
            twg_pkg::S_SMUL: r_rmag <= w_sprod_sine[46:30];
            twg_pkg::S_TWAIT: begin
                if (w_q17 >= w_peak) begin
                    r_rmag <= w_q17 - w_peak;
                    r_rneg <= 1'b0;
                end else begin
                    r_rmag <= w_peak - w_q17;
                    r_rneg <= 1'b1;
                end
            end
            twg_pkg::S_CWAIT: begin
                r_sample <= r_rneg ? 16'(17'd0 - w_mc) : w_mc[15:0];
            end
            default: ;
        endcase
    end

    assign m_axis_tdata = r_sample;
    assign m_axis_tuser = r_chan;
    assign m_axis_tlast = r_last && (r_chan || !r_stereo);

endmodule

// File: rtl/twg_chk.sv
`timescale 1ns / 1ps
// port-level checker for the tone generator, bound to the top level
module twg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // one frame in flight: never taking input while a beat is offered
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while output pending");

    // the right channel copy closes the frame
    a_right_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) |=> !m_axis_tvalid)
        else $error("output continues after right channel beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("not idle after reset");

endmodule

bind tone_waveform_generator_unit twg_chk u_twg_chk (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the tone waveform generator with its own frame predictor
module tb_top;

    localparam int TAB_N     = 1024;
    localparam int WATCH_MAX = 20000;
    localparam int SETTLE    = 200;

    typedef struct packed {
        logic [15:0] sample;
        logic        channel;
        logic        last;
    } t_tone_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] restart, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample
    logic [0:0]  m_axis_tuser;   // [0] channel
    logic        m_axis_tlast;

    tone_waveform_generator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // register mirror
    logic [1:0]  wave_sel;
    logic [12:0] tone_hz;
    logic [7:0]  amp_pct;
    logic [23:0] tone_frames;
    logic        stereo_on;
    logic        wide_on;

    // tone state mirror
    logic [23:0] frame_idx;
    logic [23:0] half_idx;
    longint      edge_frame;
    longint      half_len;
    logic        sq_high;
    logic        ramp_dn;
    longint      phase_acc;
    logic        tone_done;

    logic [31:0] quarter_sin [0:TAB_N];

    logic       restart_q[$];
    t_tone_beat expected_beats[$];
    int         fail_count;
    int         idle_mode;
    int         items_sent;
    int         watch_cnt;
    logic       took_beat;

    function automatic logic [31:0] sin_q30(input int unsigned idx);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          acc;
        int unsigned     k;
        a    = (64'd1686629713 * idx) / TAB_N;
        a2   = (a * a) >> 30;
        term = a;
        acc  = longint'(a);
        for (k = 1; k <= 7; k++) begin
            term = (term * a2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'd1073741824) acc = 64'd1073741824;
        if (idx == 0) acc = 0;
        if (idx == TAB_N) acc = 64'd1073741824;
        return 32'(acc);
    endfunction

    function automatic longint shape_amp(input longint v, input logic wide);
        longint m;
        m = (v < 0) ? -v : v;
        m = m * amp_pct / 100;
        if (v < 0) m = -m;
        if (wide) begin
            if (m >= 32767) m = 32767;
            else if (m <= -32768) m = -32768;
        end else begin
            if (m >= 127) m = 127;
            else if (m <= -127) m = -127;
        end
        return m;
    endfunction

    task automatic tone_restart();
        frame_idx  = '0;
        half_idx   = '0;
        edge_frame = -1;
        half_len   = 0;
        sq_high    = 1'b1;
        ramp_dn    = 1'b1;
        phase_acc  = 0;
        tone_done  = 1'b0;
    endtask

    // works out the beats one frame request produces
    task automatic predict_frame(input logic restart);
        longint     n;
        longint     fhz;
        longint     peak;
        longint     full;
        longint     raw;
        longint     nb;
        longint     u;
        longint     j;
        longint     q;
        longint     hl;
        longint     d;
        longint     mag;
        logic       is_last;
        t_tone_beat b;
        if (restart) tone_restart();
        if (tone_done) return;
        n = frame_idx;
        if (n >= longint'(tone_frames)) begin
            tone_done = 1'b1;
            return;
        end
        fhz = (tone_hz < 1) ? 1 : (tone_hz > 5000) ? 5000 : tone_hz;
        if (n > edge_frame) begin
            half_idx = half_idx + 1'b1;
            nb = longint'(half_idx) * 122400 / (11 * fhz);
            if (nb < n + 1) nb = n + 1;
            edge_frame = nb;
            half_len   = nb - n;
            sq_high    = !sq_high;
            ramp_dn    = !ramp_dn;
        end
        peak = wide_on ? 32767 : 127;
        full = wide_on ? 65535 : 256;
        case (wave_sel)
            twg_pkg::WAVE_SINE: begin
                u   = phase_acc * 4 * TAB_N / 244800;
                q   = (u / TAB_N) % 4;
                j   = u % TAB_N;
                mag = (q % 2 == 1) ? quarter_sin[TAB_N - j] : quarter_sin[j];
                raw = (peak * mag) >>> 30;
                if (q >= 2) raw = -raw;
            end
            twg_pkg::WAVE_SQUARE: raw = sq_high ? peak : -peak;
            twg_pkg::WAVE_TRIANGLE: begin
                hl = (half_len != 0) ? half_len : 1;
                d  = edge_frame - n;
                if (d > hl) d = hl;
                raw = full * (ramp_dn ? d : hl - d) / hl - peak;
            end
            default: raw = 0;
        endcase
        raw = shape_amp(raw, wide_on);
        phase_acc = phase_acc + 11 * fhz;
        if (phase_acc >= 244800) phase_acc = phase_acc - 244800;
        frame_idx = 24'(n + 1);
        is_last = (n + 1) >= longint'(tone_frames);
        if (is_last) tone_done = 1'b1;
        b.sample  = 16'(raw);
        b.channel = 1'b0;
        b.last    = is_last && !stereo_on;
        expected_beats.push_back(b);
        if (stereo_on) begin
            b.channel = 1'b1;
            b.last    = is_last;
            expected_beats.push_back(b);
        end
    endtask

    // input side, changes on the falling edge
    always @(negedge i_clk) begin
        logic idle;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            m_axis_tready <= 1'b0;
        end else begin
            case (idle_mode)
                0: idle = $urandom_range(99) < 38;
                1: idle = $urandom_range(99) < 50;
                default: idle = 1'b0;
            endcase
            if (s_axis_tvalid && !took_beat) begin
                // hold the beat until taken
            end else if (restart_q.size() != 0 && !idle) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, restart_q.pop_front()};
                items_sent    <= items_sent + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            case (idle_mode)
                0: m_axis_tready <= $urandom_range(99) >= 50;
                1: m_axis_tready <= $urandom_range(99) >= 38;
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // prediction, checking and watchdog on the rising edge
    always @(posedge i_clk) begin
        t_tone_beat exp_b;
        took_beat <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_frame(s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat sample=%h channel=%b last=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count = fail_count + 1;
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (m_axis_tdata !== exp_b.sample) begin
                        $display("%0t: sample expected %h actual %h",
                                 $time, exp_b.sample, m_axis_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tuser[0] !== exp_b.channel) begin
                        $display("%0t: channel expected %b actual %b",
                                 $time, exp_b.channel, m_axis_tuser[0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tlast !== exp_b.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_b.last, m_axis_tlast);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                watch_cnt <= 0;
            else
                watch_cnt <= watch_cnt + 1;
            if (watch_cnt >= WATCH_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        case (idx)
            twg_pkg::CFG_WAVEFORM:  wave_sel    = val[1:0];
            twg_pkg::CFG_FREQUENCY: tone_hz     = val[12:0];
            twg_pkg::CFG_AMPLITUDE: amp_pct     = val[7:0];
            twg_pkg::CFG_FRAMES:    tone_frames = val;
            twg_pkg::CFG_STEREO:    stereo_on   = val[0];
            default:                wide_on     = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_tone(input logic [1:0] wv, input logic [12:0] hz, input logic [7:0] pct,
                            input logic [23:0] frames, input logic st, input logic wd);
        write_reg(twg_pkg::CFG_WAVEFORM, 24'(wv));
        write_reg(twg_pkg::CFG_FREQUENCY, 24'(hz));
        write_reg(twg_pkg::CFG_AMPLITUDE, 24'(pct));
        write_reg(twg_pkg::CFG_FRAMES, frames);
        write_reg(twg_pkg::CFG_STEREO, 24'(st));
        write_reg(twg_pkg::CFG_WIDTH, 24'(wd));
    endtask

    // waits until every frame is taken and answered, then lets the block settle
    task automatic drain();
        while (restart_q.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_frames(input logic restart, input int steps);
        restart_q.push_back(restart);
        repeat (steps) restart_q.push_back(1'b0);
        drain();
    endtask

    initial begin
        int          steps;
        logic [23:0] frames;
        logic [12:0] hz;
        for (int i = 0; i <= TAB_N; i++) quarter_sin[i] = sin_q30(i);
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        fail_count = 0;
        idle_mode  = 0;
        items_sent = 0;
        watch_cnt  = 0;
        took_beat  = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        wave_sel    = twg_pkg::WAVE_SILENCE;
        tone_hz     = 13'd440;
        amp_pct     = 8'd100;
        tone_frames = 24'd1;
        stereo_on   = 1'b0;
        wide_on     = 1'b1;
        tone_restart();
        tone_done = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // finished after reset, then one silent frame with defaults
        run_frames(1'b0, 0);
        run_frames(1'b1, 1);
        set_tone(twg_pkg::WAVE_SINE, 13'd5000, 8'd100, 24'd10, 1'b1, 1'b1);
        run_frames(1'b1, 10);
        // frequency below range acts as one hertz, amplitude at its top
        set_tone(twg_pkg::WAVE_SQUARE, 13'd0, 8'd255, 24'd4, 1'b0, 1'b0);
        run_frames(1'b1, 3);
        set_tone(twg_pkg::WAVE_TRIANGLE, 13'h1FFF, 8'd0, 24'd0, 1'b1, 1'b0);
        run_frames(1'b1, 1);
        // frequency change mid-tone, then frame count shrunk below position
        set_tone(twg_pkg::WAVE_TRIANGLE, 13'd3000, 8'd150, 24'hFFFFFF, 1'b0, 1'b1);
        run_frames(1'b1, 3);
        write_reg(twg_pkg::CFG_FREQUENCY, 24'd1);
        run_frames(1'b0, 2);
        write_reg(twg_pkg::CFG_FRAMES, 24'd2);
        run_frames(1'b0, 1);

        while (items_sent < 950) begin
            if (items_sent > 630) idle_mode = 2;
            else if (items_sent > 320) idle_mode = 1;
            frames = ($urandom_range(15) == 0) ? 24'($urandom) : 24'($urandom_range(40, 1));
            if ($urandom_range(20) == 0) frames = 24'd0;
            hz = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(5000, 1));
            set_tone(2'($urandom), hz, 8'($urandom), frames, 1'($urandom), 1'($urandom));
            steps = $urandom_range(45);
            restart_q.push_back($urandom_range(3) != 0);
            for (int k = 0; k < steps; k++) restart_q.push_back($urandom_range(29) == 0);
            drain();
        end
        drain();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
